// File: rtl/core/fagt_pkg.sv
// ----------------------------------------------------------------------------
// File access grant table package
// Shared constants and types for the access grant table.
// ----------------------------------------------------------------------------
package fagt_pkg;

    localparam int TableEntries = 64;
    localparam int UsersPerFile = 8;
    localparam int TiW = $clog2(TableEntries);
    localparam int UiW = $clog2(UsersPerFile);
    localparam int SlotW = TiW + UiW;
    localparam int CntW = $clog2(UsersPerFile + 1);

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DENIED = 2'd1;
    localparam logic [1:0] ST_NOFILE = 2'd2;
    localparam logic [1:0] ST_YIELD_FAIL = 2'd3;

    localparam logic [1:0] MODE_RD = 2'd0;
    localparam logic [1:0] MODE_RW = 2'd2;

    localparam logic [8:0] PERM_RD_OWNER = 9'o400;
    localparam logic [8:0] PERM_WR_OWNER = 9'o200;
    localparam logic [8:0] PERM_RD_OTHER = 9'o004;
    localparam logic [8:0] PERM_WR_OTHER = 9'o002;

    typedef enum logic [3:0] {
        S_IDLE,
        S_YIELD,
        S_SCAN,
        S_SCAN_WAIT,
        S_SLOT,
        S_SLOT_WAIT,
        S_FREE,
        S_CREATE,
        S_CLEAR,
        S_DONE
    } state_t;

    function automatic logic perm_ok(input logic is_owner, input logic [1:0] mode,
                                     input logic [8:0] perm);
        logic rd;
        logic wr;
        rd = |(perm & (is_owner ? PERM_RD_OWNER : PERM_RD_OTHER));
        wr = |(perm & (is_owner ? PERM_WR_OWNER : PERM_WR_OTHER));
        if (mode == MODE_RD)
            return rd;
        else if (mode == MODE_RW)
            return rd && wr;
        else
            return wr;
    endfunction

endpackage

// File: rtl/core/fagt_entry_mem.sv
// ----------------------------------------------------------------------------
// Entry memory
// Per-entry key, owner, permissions, count and slot valid bits, with used bits
// in flip-flops and a registered read.
// ----------------------------------------------------------------------------
module fagt_entry_mem
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [fagt_pkg::TiW-1:0]    rd_addr,
    output logic                        rd_used,
    output logic [63:0]                 rd_key,
    output logic [30:0]                 rd_owner,
    output logic [8:0]                  rd_perm,
    output logic [fagt_pkg::CntW-1:0]   rd_count,
    output logic [fagt_pkg::UsersPerFile-1:0] rd_valid,
    input  logic                        wr_meta,
    input  logic                        wr_aux,
    input  logic [fagt_pkg::TiW-1:0]    wr_addr,
    input  logic [63:0]                 wr_key,
    input  logic [30:0]                 wr_owner,
    input  logic [8:0]                  wr_perm,
    input  logic [fagt_pkg::CntW-1:0]   wr_count,
    input  logic [fagt_pkg::UsersPerFile-1:0] wr_valid
);
    import fagt_pkg::*;

    localparam int AuxW = CntW + UsersPerFile;

    logic [TableEntries-1:0] used_reg;
    logic [TableEntries-1:0] aux_ok_reg;
    logic [103:0]            meta_mem [TableEntries];
    logic [AuxW-1:0]         aux_mem [TableEntries];
    logic [103:0]            meta_q;
    logic [AuxW-1:0]         aux_q;
    logic                    used_q;
    logic                    aux_ok_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            aux_ok_reg <= '0;
            used_q     <= 1'b0;
            aux_ok_q   <= 1'b0;
        end
        else
        begin
            if (wr_meta)
                used_reg[wr_addr] <= 1'b1;
            if (wr_aux)
                aux_ok_reg[wr_addr] <= 1'b1;
            used_q   <= used_reg[rd_addr];
            aux_ok_q <= aux_ok_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_meta)
            meta_mem[wr_addr] <= {wr_key, wr_owner, wr_perm};
        if (wr_aux)
            aux_mem[wr_addr] <= {wr_count, wr_valid};
        meta_q <= meta_mem[rd_addr];
        aux_q  <= aux_mem[rd_addr];
    end

    assign rd_used  = used_q;
    assign rd_key   = meta_q[103:40];
    assign rd_owner = meta_q[39:9];
    assign rd_perm  = meta_q[8:0];
    assign rd_count = aux_ok_q ? aux_q[AuxW-1:UsersPerFile] : '0;
    assign rd_valid = aux_ok_q ? aux_q[UsersPerFile-1:0] : '0;

endmodule

// File: rtl/core/fagt_slot_mem.sv
// ----------------------------------------------------------------------------
// Slot memory
// User identifiers of all slots, with a registered read.
// ----------------------------------------------------------------------------
module fagt_slot_mem
(
    input  logic                         clk,
    input  logic [fagt_pkg::SlotW-1:0]   rd_addr,
    output logic [30:0]                  rd_user,
    input  logic                         wr_en,
    input  logic [fagt_pkg::SlotW-1:0]   wr_addr,
    input  logic [30:0]                  wr_user
);
    import fagt_pkg::*;

    logic [30:0] mem [TableEntries*UsersPerFile];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_user;
        rd_user <= mem[rd_addr];
    end

endmodule

// File: rtl/core/file_access_grant_table_unit.sv
// ----------------------------------------------------------------------------
// File access grant table unit
// Grants and releases user access to entries of an open-file table.
// ----------------------------------------------------------------------------
// A yield item passes through the yield, clear and done states, or straight
// from yield to done when an index is out of range. A grant scans the entry
// memory one entry at a time, waiting out the read latency of each, then the
// matching entry's user slots one at a time, then, when no slot matches, the
// free-slot pick or, on a miss with create, a scan for the first unused
// entry. The scans are paced by the single read port of each memory. The
// result appears for one cycle with done high and must be taken then.
module file_access_grant_table_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [63:0] file_key,
    input  logic [30:0] user_id,
    input  logic [1:0]  access_mode,
    input  logic        create,
    input  logic [8:0]  new_permission,
    input  logic [6:0]  release_table_index,
    input  logic [3:0]  release_user_index,
    output logic        done,
    output logic [1:0]  status,
    output logic [5:0]  table_index,
    output logic [2:0]  user_index
);
    import fagt_pkg::*;

    state_t state_reg, state_next;

    logic [63:0]       key_reg;
    logic [30:0]       uid_reg;
    logic [1:0]        mode_reg;
    logic              create_reg;
    logic [8:0]        perm_reg;
    logic [6:0]        rti_reg;
    logic [3:0]        rui_reg;
    logic [TiW:0]      ei_reg;
    logic [UiW:0]      sj_reg;
    logic              ok_reg;
    logic [CntW-1:0]   cnt_reg;
    logic [UsersPerFile-1:0] val_reg;
    logic [1:0]        st_reg;
    logic [5:0]        ti_reg;
    logic [2:0]        ui_reg;
    logic              done_reg;

    logic              rd_used;
    logic [63:0]       rd_key;
    logic [30:0]       rd_owner;
    logic [8:0]        rd_perm;
    logic [CntW-1:0]   rd_count;
    logic [UsersPerFile-1:0] rd_valid;
    logic [30:0]       rd_user;

    logic              wr_meta, wr_aux, slot_we;
    logic [TiW-1:0]    ent_addr, wr_addr;
    logic [CntW-1:0]   wr_count;
    logic [UsersPerFile-1:0] wr_valid;
    logic [SlotW-1:0]  slot_addr;
    logic [SlotW-1:0]  slot_wr_addr;
    logic              range_bad;
    logic              free_found;
    logic [UiW-1:0]    free_idx;
    logic [UsersPerFile-1:0] one_hot0;

    assign range_bad = (rti_reg >= 7'(TableEntries)) || (rui_reg >= 4'(UsersPerFile));
    assign one_hot0 = UsersPerFile'(1);

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = UsersPerFile - 1; k >= 0; k--)
        begin
            if (!val_reg[k])
            begin
                free_found = 1'b1;
                free_idx   = UiW'(k);
            end
        end
    end

    always_comb
    begin
        priority if (state_reg == S_YIELD || state_reg == S_IDLE)
            ent_addr = rti_reg[TiW-1:0];
        else
            ent_addr = ei_reg[TiW-1:0];
    end

    assign slot_addr = {ei_reg[TiW-1:0], sj_reg[UiW-1:0]};
    assign slot_wr_addr = (state_reg == S_CREATE) ? {wr_addr, UiW'(0)}
                                                  : {ei_reg[TiW-1:0], free_idx};

    fagt_entry_mem u_entry (
        .clk(clk), .rst_n(rst_n), .rd_addr(ent_addr),
        .rd_used(rd_used), .rd_key(rd_key), .rd_owner(rd_owner), .rd_perm(rd_perm),
        .rd_count(rd_count), .rd_valid(rd_valid),
        .wr_meta(wr_meta), .wr_aux(wr_aux), .wr_addr(wr_addr),
        .wr_key(key_reg), .wr_owner(uid_reg), .wr_perm(perm_reg),
        .wr_count(wr_count), .wr_valid(wr_valid)
    );

    fagt_slot_mem u_slot (
        .clk(clk), .rd_addr(slot_addr), .rd_user(rd_user),
        .wr_en(slot_we), .wr_addr(slot_wr_addr), .wr_user(uid_reg)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (start) state_next = (op ? S_YIELD : S_SCAN);
            S_YIELD:     state_next = range_bad ? S_DONE : S_CLEAR;
            S_CLEAR:     state_next = S_DONE;
            S_SCAN:      state_next = S_SCAN_WAIT;
            S_SCAN_WAIT:
            begin
                if (rd_used && rd_key == key_reg)
                    state_next = S_SLOT;
                else if (ei_reg == (TiW+1)'(TableEntries - 1))
                    state_next = create_reg ? S_CREATE : S_DONE;
                else
                    state_next = S_SCAN;
            end
            S_SLOT:      state_next = S_SLOT_WAIT;
            S_SLOT_WAIT:
            begin
                if (val_reg[sj_reg[UiW-1:0]] && rd_user == uid_reg)
                    state_next = S_DONE;
                else if (sj_reg == (UiW+1)'(UsersPerFile - 1))
                    state_next = S_FREE;
                else
                    state_next = S_SLOT;
            end
            S_FREE:      state_next = S_DONE;
            S_CREATE:
            begin
                if (!rd_used && ei_reg != (TiW+1)'(0) && ei_reg <= (TiW+1)'(TableEntries))
                    state_next = S_DONE;
                else if (ei_reg == (TiW+1)'(TableEntries))
                    state_next = S_DONE;
                else
                    state_next = S_CREATE;
            end
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Create scan: ei counts addresses issued; the used bit seen in a cycle
    // belongs to address ei-1.
    always_comb
    begin
        wr_meta  = 1'b0;
        wr_aux   = 1'b0;
        slot_we  = 1'b0;
        wr_addr  = ei_reg[TiW-1:0];
        wr_count = cnt_reg;
        wr_valid = val_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_aux   = 1'b1;
                wr_addr  = rti_reg[TiW-1:0];
                wr_valid = rd_valid & ~(UsersPerFile'(1) << rui_reg[UiW-1:0]);
                wr_count = (rd_count == '0) ? '0 : rd_count - CntW'(1);
            end
            S_FREE:
            begin
                if (cnt_reg < CntW'(UsersPerFile) && ok_reg && free_found)
                begin
                    wr_aux   = 1'b1;
                    wr_valid = val_reg | (UsersPerFile'(1) << free_idx);
                    wr_count = cnt_reg + CntW'(1);
                end
            end
            S_CREATE:
            begin
                wr_addr = TiW'(ei_reg - (TiW+1)'(1));
                if (!rd_used && ei_reg != (TiW+1)'(0))
                begin
                    wr_meta  = 1'b1;
                    wr_aux   = 1'b1;
                    wr_count = CntW'(1);
                    wr_valid = one_hot0;
                end
            end
            default: ;
        endcase
        slot_we = ((state_reg == S_FREE) && wr_aux) || ((state_reg == S_CREATE) && wr_meta);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_next == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                key_reg    <= file_key;
                uid_reg    <= user_id;
                mode_reg   <= access_mode;
                create_reg <= create;
                perm_reg   <= new_permission;
                rti_reg    <= release_table_index;
                rui_reg    <= release_user_index;
                ei_reg     <= '0;
                sj_reg     <= '0;
                st_reg     <= ST_NOFILE;
                ti_reg     <= '0;
                ui_reg     <= '0;
            end
            S_YIELD:
                st_reg <= ST_YIELD_FAIL;
            S_CLEAR:
                st_reg <= (rd_count == '0) ? ST_YIELD_FAIL : ST_OK;
            S_SCAN_WAIT:
            begin
                if (rd_used && rd_key == key_reg)
                begin
                    ok_reg  <= perm_ok(uid_reg == rd_owner, mode_reg, rd_perm);
                    cnt_reg <= rd_count;
                    val_reg <= rd_valid;
                    sj_reg  <= '0;
                end
                else if (ei_reg == (TiW+1)'(TableEntries - 1))
                    ei_reg <= '0;
                else
                    ei_reg <= ei_reg + (TiW+1)'(1);
            end
            S_SLOT_WAIT:
            begin
                if (val_reg[sj_reg[UiW-1:0]] && rd_user == uid_reg)
                begin
                    st_reg <= ok_reg ? ST_OK : ST_DENIED;
                    ti_reg <= ok_reg ? 6'(ei_reg) : '0;
                    ui_reg <= ok_reg ? 3'(sj_reg) : '0;
                end
                else if (sj_reg != (UiW+1)'(UsersPerFile - 1))
                    sj_reg <= sj_reg + (UiW+1)'(1);
            end
            S_FREE:
            begin
                sj_reg <= (UiW+1)'(free_idx);
                if (wr_aux)
                begin
                    st_reg <= ST_OK;
                    ti_reg <= 6'(ei_reg);
                    ui_reg <= 3'(free_idx);
                end
                else
                    st_reg <= ST_DENIED;
            end
            S_CREATE:
            begin
                if (!rd_used && ei_reg != (TiW+1)'(0))
                begin
                    st_reg <= ST_OK;
                    ti_reg <= 6'(ei_reg - (TiW+1)'(1));
                    ui_reg <= '0;
                end
                else
                    ei_reg <= ei_reg + (TiW+1)'(1);
            end
            default: ;
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = st_reg;
    assign table_index = ti_reg;
    assign user_index  = ui_reg;

endmodule

// File: test/file_access_grant_table_unit_test.sv
// ----------------------------------------------------------------------------
// File access grant table unit testbench
// Drives grant and yield requests through the start/busy handshake with
// random gaps, predicts each result from its own copy of the entry table and
// compares every done strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module file_access_grant_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fagt_pkg::*;

    localparam logic OP_GRANT = 1'b0;
    localparam logic OP_YIELD = 1'b1;
    localparam logic [1:0] MODE_WR = 2'd1;
    localparam logic [1:0] MODE_WR_ALT = 2'd3;
    localparam int NumKeys = 72;
    localparam int NumUsers = 10;

    typedef struct {
        logic        op;
        logic [63:0] key;
        logic [30:0] uid;
        logic [1:0]  mode;
        logic        create;
        logic [8:0]  perm;
        logic [6:0]  rti;
        logic [3:0]  rui;
        logic        drain;
    } access_req_t;

    typedef struct {
        logic [1:0] status;
        logic [5:0] ti;
        logic [2:0] ui;
    } grant_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start;
    logic        busy;
    logic        op;
    logic [63:0] file_key;
    logic [30:0] user_id;
    logic [1:0]  access_mode;
    logic        create;
    logic [8:0]  new_permission;
    logic [6:0]  release_table_index;
    logic [3:0]  release_user_index;
    logic        done;
    logic [1:0]  status;
    logic [5:0]  table_index;
    logic [2:0]  user_index;

    access_req_t   pending_reqs[$];
    grant_result_t expected_results[$];
    access_req_t   cur_req;
    int            gap_left;
    int            failures = 0;

    logic         tbl_used[TableEntries];
    logic [63:0]  tbl_key[TableEntries];
    logic [30:0]  tbl_owner[TableEntries];
    logic [8:0]   tbl_perm[TableEntries];
    int           tbl_count[TableEntries];
    logic         tbl_slot_valid[TableEntries][UsersPerFile];
    logic [30:0]  tbl_slot_user[TableEntries][UsersPerFile];

    logic [63:0]  key_pool[NumKeys];
    logic [30:0]  user_pool[NumUsers];

    file_access_grant_table_unit dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic access_allowed(logic [30:0] uid, logic [1:0] mode, int e);
        logic rd;
        logic wr;
        if (uid == tbl_owner[e])
        begin
            rd = (tbl_perm[e] & PERM_RD_OWNER) != 0;
            wr = (tbl_perm[e] & PERM_WR_OWNER) != 0;
        end
        else
        begin
            rd = (tbl_perm[e] & PERM_RD_OTHER) != 0;
            wr = (tbl_perm[e] & PERM_WR_OTHER) != 0;
        end
        if (mode == MODE_RD)
            return rd;
        if (mode == MODE_RW)
            return rd && wr;
        return wr;
    endfunction

    function automatic grant_result_t apply_request(access_req_t r);
        grant_result_t res;
        int hit;
        logic ok;
        res = '{ST_NOFILE, 6'd0, 3'd0};
        hit = -1;
        if (r.op == OP_YIELD)
        begin
            res.status = ST_YIELD_FAIL;
            if (r.rti < TableEntries && r.rui < UsersPerFile)
            begin
                tbl_slot_valid[r.rti][r.rui] = 1'b0;
                if (tbl_count[r.rti] != 0)
                begin
                    tbl_count[r.rti]--;
                    res.status = ST_OK;
                end
            end
            return res;
        end
        for (int i = 0; i < TableEntries; i++)
            if (hit < 0 && tbl_used[i] && tbl_key[i] == r.key)
                hit = i;
        if (hit >= 0)
        begin
            ok = access_allowed(r.uid, r.mode, hit);
            res.status = ST_DENIED;
            for (int j = 0; j < UsersPerFile; j++)
                if (tbl_slot_valid[hit][j] && tbl_slot_user[hit][j] == r.uid)
                begin
                    if (ok)
                        res = '{ST_OK, hit[5:0], j[2:0]};
                    return res;
                end
            if (tbl_count[hit] >= UsersPerFile || !ok)
                return res;
            for (int j = 0; j < UsersPerFile; j++)
                if (!tbl_slot_valid[hit][j])
                begin
                    tbl_slot_valid[hit][j] = 1'b1;
                    tbl_slot_user[hit][j] = r.uid;
                    tbl_count[hit]++;
                    res = '{ST_OK, hit[5:0], j[2:0]};
                    return res;
                end
            return res;
        end
        if (r.create)
            for (int i = 0; i < TableEntries; i++)
                if (!tbl_used[i])
                begin
                    tbl_used[i] = 1'b1;
                    tbl_key[i] = r.key;
                    tbl_owner[i] = r.uid;
                    tbl_perm[i] = r.perm;
                    tbl_count[i] = 1;
                    for (int j = 0; j < UsersPerFile; j++)
                        tbl_slot_valid[i][j] = 1'b0;
                    tbl_slot_valid[i][0] = 1'b1;
                    tbl_slot_user[i][0] = r.uid;
                    res = '{ST_OK, i[5:0], 3'd0};
                    return res;
                end
        return res;
    endfunction

    function automatic access_req_t noise_req();
        access_req_t r;
        r.op = OP_GRANT;
        r.key = {$urandom, $urandom};
        r.uid = 31'($urandom);
        r.mode = 2'($urandom);
        r.create = 1'($urandom);
        r.perm = 9'($urandom);
        r.rti = 7'($urandom);
        r.rui = 4'($urandom);
        r.drain = 1'b0;
        return r;
    endfunction

    task automatic add_grant(logic [63:0] key, logic [30:0] uid, logic [1:0] mode,
                             logic cr, logic [8:0] perm);
        access_req_t r;
        r = noise_req();
        r.key = key;
        r.uid = uid;
        r.mode = mode;
        r.create = cr;
        r.perm = perm;
        pending_reqs.push_back(r);
    endtask

    task automatic add_yield(logic [6:0] rti, logic [3:0] rui);
        access_req_t r;
        r = noise_req();
        r.op = OP_YIELD;
        r.rti = rti;
        r.rui = rui;
        pending_reqs.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            op <= OP_GRANT;
            file_key <= '0;
            user_id <= '0;
            access_mode <= MODE_RD;
            create <= 1'b0;
            new_permission <= '0;
            release_table_index <= '0;
            release_user_index <= '0;
            gap_left = 0;
        end
        else if (!(start && busy))
        begin
            if (start)
                expected_results.push_back(apply_request(cur_req));
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_results.size() > 0))
            begin
                cur_req = pending_reqs.pop_front();
                op <= cur_req.op;
                file_key <= cur_req.key;
                user_id <= cur_req.uid;
                access_mode <= cur_req.mode;
                create <= cur_req.create;
                new_permission <= cur_req.perm;
                release_table_index <= cur_req.rti;
                release_user_index <= cur_req.rui;
                start <= 1'b1;
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: status %0d", status);
                failures++;
            end
            else
            begin
                grant_result_t e;
                e = expected_results.pop_front();
                if (status !== e.status)
                begin
                    $error("status: expected %0d, actual %0d", e.status, status);
                    failures++;
                end
                if (table_index !== e.ti)
                begin
                    $error("table_index: expected %0d, actual %0d", e.ti, table_index);
                    failures++;
                end
                if (user_index !== e.ui)
                begin
                    $error("user_index: expected %0d, actual %0d", e.ui, user_index);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        #30ms;
        $display("file_access_grant_table_unit_test: FAIL");
        $finish;
    end

    initial
    begin
        access_req_t r;
        foreach (tbl_used[i])
        begin
            tbl_used[i] = 1'b0;
            tbl_count[i] = 0;
            foreach (tbl_slot_valid[i][j])
                tbl_slot_valid[i][j] = 1'b0;
        end
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        foreach (user_pool[i])
            user_pool[i] = 31'($urandom);
        user_pool[0] = '0;
        user_pool[1] = '1;

        // Directed: missing file, create, owner and other checks, full list.
        add_grant(key_pool[0], user_pool[0], MODE_RD, 1'b0, 9'o777);
        add_grant(key_pool[0], user_pool[0], MODE_RD, 1'b1, 9'o640);
        add_grant(key_pool[0], user_pool[0], MODE_RW, 1'b0, 9'o000);
        add_grant(key_pool[0], user_pool[1], MODE_RD, 1'b0, 9'o000);
        add_grant(key_pool[1], user_pool[1], MODE_WR_ALT, 1'b1, 9'o777);
        for (int k = 2; k < 10; k++)
            add_grant(key_pool[1], user_pool[k], 2'(k), 1'b0, 9'o000);
        add_yield(7'd64, 4'd0);
        add_yield(7'd0, 4'd8);
        add_yield(7'd127, 4'd15);
        add_yield(7'd0, 4'd0);
        add_yield(7'd0, 4'd0);
        // Yielding a free slot still lowers the count below the used slots.
        add_yield(7'd1, 4'd7);
        add_yield(7'd1, 4'd7);
        add_grant(key_pool[1], 31'h1234567, MODE_WR, 1'b0, 9'o000);
        add_grant(key_pool[1], 31'h7654321, MODE_RD, 1'b0, 9'o000);
        add_grant(key_pool[2], user_pool[2], MODE_RD, 1'b1, 9'o000);
        add_yield(7'd5, 4'd3);

        for (int n = 0; n < 1250; n++)
        begin
            r = noise_req();
            if ($urandom_range(0, 99) < 15)
            begin
                r.op = OP_YIELD;
                if ($urandom_range(0, 9) != 0)
                begin
                    r.rti = 7'($urandom_range(0, 63));
                    r.rui = 4'($urandom_range(0, 7));
                end
            end
            else
            begin
                if ($urandom_range(0, 19) != 0)
                    r.key = key_pool[$urandom_range(0, NumKeys - 1)];
                if ($urandom_range(0, 19) != 0)
                    r.uid = user_pool[$urandom_range(0, NumUsers - 1)];
            end
            r.drain = (n == 600);
            pending_reqs.push_back(r);
        end

        repeat (2) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        wait (pending_reqs.size() == 0 && !start && expected_results.size() == 0);
        repeat (400) @(posedge clk);
        if (failures == 0 && expected_results.size() == 0)
            $display("file_access_grant_table_unit_test: PASS");
        else
            $display("file_access_grant_table_unit_test: FAIL");
        $finish;
    end
endmodule

// File: files.f
rtl/core/fagt_pkg.sv
rtl/core/fagt_entry_mem.sv
rtl/core/fagt_slot_mem.sv
rtl/core/file_access_grant_table_unit.sv
test/file_access_grant_table_unit_test.sv
